// ----- src/bjpq_pkg.sv -----
// Shared types and constants for the bounded job priority queue.
package bjpq_pkg;

  localparam int unsigned OCC_W = 4;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_PUSHED    = 3'd0,
    ST_PUSH_FULL = 3'd1,
    ST_OVER_LIM  = 3'd2,
    ST_POPPED    = 3'd3,
    ST_POP_EMPTY = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_POP_RD,
    SEQ_SHIFT,
    SEQ_PLACE,
    SEQ_RESP
  } seq_state_e;

  // One stored job
  typedef struct packed {
    logic [3:0]  prio;
    logic [7:0]  producer_number;
    logic [21:0] producer_pid;
    logic [3:0]  compute_time;
    logic [16:0] job_tag;
  } job_t;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  priority_req;
    logic [7:0]  producer_number;
    logic [21:0] producer_pid;
    logic [3:0]  compute_time;
    logic [16:0] job_tag;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [3:0]       out_priority;
    logic [7:0]       out_producer_number;
    logic [21:0]      out_producer_pid;
    logic [3:0]       out_compute_time;
    logic [16:0]      out_job_tag;
    logic [OCC_W-1:0] occupancy;
    logic [15:0]      created_total;
    logic [15:0]      completed_total;
  } rsp_t;

endpackage

// ----- src/bjpq_ring.sv -----
// Ring-buffer job store addressed by queue position relative to the head.
module bjpq_ring #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] wpos_i,
  input  bjpq_pkg::job_t                 wdata_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] rpos_i,
  input  logic                           advance_i,
  output bjpq_pkg::job_t                 rdata_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  bjpq_pkg::job_t mem [QUEUE_DEPTH];
  bjpq_pkg::job_t rdata_q;
  logic [AW-1:0]  head_q;
  logic [AW-1:0]  head_d;
  logic [AW-1:0]  waddr;
  logic [AW-1:0]  raddr;

  // Map a queue position to a physical slot, wrapping once past the end.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [AW-1:0] pos);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (AW+1)'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign waddr  = phys(head_q, wpos_i);
  assign raddr  = phys(head_q, rpos_i);
  assign head_d = phys(head_q, AW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else if (advance_i) begin
      head_q <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr] <= wdata_i;
    end
    rdata_q <= mem[raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/bounded_job_priority_queue.sv -----
// Pop: request accepted, one memory read, result registered.
// Push: SEQ_SHIFT moves each entry of equal or lower priority back one slot until a
//   higher-priority entry or the head ends the scan, then SEQ_PLACE writes the job.
// Rejected push or empty pop: straight to the response. One request is in work at a time; the
//   result register frees the sequencer unless the previous result is still stalled.
// Reset clears sequencer, counters, job_limit and head; stored jobs are not cleared.
module bounded_job_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bjpq_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bjpq_pkg::rsp_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_data_i
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  bjpq_pkg::seq_state_e state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [15:0]          created_q, created_d;
  logic [15:0]          completed_q, completed_d;
  logic [15:0]          limit_q;
  logic [AW-1:0]        pos_q, pos_d;
  bjpq_pkg::job_t       job_q, job_d;
  bjpq_pkg::job_t       pop_q, pop_d;
  bjpq_pkg::status_e    status_q, status_d;
  logic                 out_valid_q, out_valid_d;
  bjpq_pkg::rsp_t       out_q, out_d;

  logic                 mem_we;
  logic [AW-1:0]        mem_wpos;
  bjpq_pkg::job_t       mem_wdata;
  logic [AW-1:0]        mem_rpos;
  logic                 mem_advance;
  bjpq_pkg::job_t       mem_rdata;
  logic [CW-1:0]        count_m1;
  logic                 out_free;

  bjpq_ring #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (mem_we),
    .wpos_i    (mem_wpos),
    .wdata_i   (mem_wdata),
    .rpos_i    (mem_rpos),
    .advance_i (mem_advance),
    .rdata_o   (mem_rdata)
  );

  assign count_m1   = count_q - CW'(1);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != bjpq_pkg::SEQ_IDLE);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    created_d   = created_q;
    completed_d = completed_q;
    pos_d       = pos_q;
    job_d       = job_q;
    pop_d       = pop_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_wpos    = pos_q;
    mem_wdata   = job_q;
    mem_rpos    = '0;
    mem_advance = 1'b0;

    case (state_q)
      bjpq_pkg::SEQ_IDLE: begin
        if (in_valid_i) begin
          job_d.prio            = in_data_i.priority_req;
          job_d.producer_number = in_data_i.producer_number;
          job_d.producer_pid    = in_data_i.producer_pid;
          job_d.compute_time    = in_data_i.compute_time;
          job_d.job_tag         = in_data_i.job_tag;
          pop_d                 = '0;
          if (in_data_i.cmd == bjpq_pkg::CMD_POP) begin
            if (count_q == '0) begin
              status_d = bjpq_pkg::ST_POP_EMPTY;
              state_d  = bjpq_pkg::SEQ_RESP;
            end else begin
              mem_rpos = '0;
              state_d  = bjpq_pkg::SEQ_POP_RD;
            end
          end else if (created_q >= limit_q) begin
            status_d = bjpq_pkg::ST_OVER_LIM;
            state_d  = bjpq_pkg::SEQ_RESP;
          end else if (count_q == CW'(QUEUE_DEPTH)) begin
            status_d = bjpq_pkg::ST_PUSH_FULL;
            state_d  = bjpq_pkg::SEQ_RESP;
          end else begin
            pos_d = count_q[AW-1:0];
            if (count_q == '0) begin
              state_d = bjpq_pkg::SEQ_PLACE;
            end else begin
              mem_rpos = count_m1[AW-1:0];
              state_d  = bjpq_pkg::SEQ_SHIFT;
            end
          end
        end
      end
      bjpq_pkg::SEQ_POP_RD: begin
        pop_d       = mem_rdata;
        mem_advance = 1'b1;
        count_d     = count_m1;
        completed_d = completed_q + 16'd1;
        status_d    = bjpq_pkg::ST_POPPED;
        state_d     = bjpq_pkg::SEQ_RESP;
      end
      bjpq_pkg::SEQ_SHIFT: begin
        // Move the entry one slot back while the new job ranks at or above it.
        if (job_q.prio >= mem_rdata.prio) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          pos_d     = pos_q - AW'(1);
          if (pos_q == AW'(1)) begin
            state_d = bjpq_pkg::SEQ_PLACE;
          end else begin
            mem_rpos = pos_q - AW'(1) - AW'(1);
          end
        end else begin
          state_d = bjpq_pkg::SEQ_PLACE;
        end
      end
      bjpq_pkg::SEQ_PLACE: begin
        mem_we    = 1'b1;
        count_d   = count_q + CW'(1);
        created_d = created_q + 16'd1;
        status_d  = bjpq_pkg::ST_PUSHED;
        state_d   = bjpq_pkg::SEQ_RESP;
      end
      bjpq_pkg::SEQ_RESP: begin
        if (out_free) begin
          out_valid_d               = 1'b1;
          out_d.status              = status_q;
          out_d.out_priority        = pop_q.prio;
          out_d.out_producer_number = pop_q.producer_number;
          out_d.out_producer_pid    = pop_q.producer_pid;
          out_d.out_compute_time    = pop_q.compute_time;
          out_d.out_job_tag         = pop_q.job_tag;
          out_d.occupancy           = bjpq_pkg::OCC_W'(count_q);
          out_d.created_total       = created_q;
          out_d.completed_total     = completed_q;
          state_d                   = bjpq_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_d = bjpq_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bjpq_pkg::SEQ_IDLE;
      count_q     <= '0;
      created_q   <= '0;
      completed_q <= '0;
      limit_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      created_q   <= created_d;
      completed_q <= completed_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    job_q    <= job_d;
    pop_q    <= pop_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- src/bjpq_checker.sv -----
// Port-level checks for the bounded job priority queue, bound to the top level.
module bjpq_checker #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input bjpq_pkg::rsp_t out_data_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result dropped or changed");

  // One request in work at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous one in work");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.occupancy <= bjpq_pkg::OCC_W'(QUEUE_DEPTH))
    else $error("occupancy beyond depth");

  a_completed_le_created: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.completed_total <= out_data_o.created_total)
    else $error("more jobs completed than created");

  a_empty_means_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == bjpq_pkg::ST_POP_EMPTY
      |-> out_data_o.occupancy == '0 && out_data_o.out_job_tag == '0)
    else $error("empty pop with jobs waiting or payload set");

endmodule

bind bounded_job_priority_queue bjpq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_bjpq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- tb/sv/tb_bounded_job_priority_queue.sv -----
// Self-checking testbench for the bounded job priority queue.
`timescale 1ns / 100ps

module tb_bounded_job_priority_queue;

  localparam int unsigned DEPTH        = 8;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned LONG_HOLD    = 120;

  logic           clk      = 1'b0;
  logic           rst_n    = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  bjpq_pkg::req_t in_data  = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  bjpq_pkg::rsp_t out_data;
  logic           cfg_we   = 1'b0;
  logic [15:0]    cfg_data = '0;

  // Requests waiting to be offered and responses still owed by the queue
  bjpq_pkg::req_t req_backlog[$];
  bjpq_pkg::rsp_t rsp_due[$];

  // Shadow copy of the queue contents, counters and job limit
  bjpq_pkg::job_t shadow_jobs[DEPTH];
  int unsigned    shadow_fill    = 0;
  int unsigned    shadow_created = 0;
  int unsigned    shadow_done    = 0;
  logic [15:0]    shadow_limit   = '0;

  int unsigned reqs_taken  = 0;
  int unsigned rsps_seen   = 0;
  int unsigned mismatches  = 0;
  int unsigned status_tally[8];
  int unsigned limits_set  = 0;
  int unsigned quiet_cycles = 0;

  // Sender burst shaping
  int unsigned burst_left = 0;
  int unsigned send_gap   = 0;

  // Receiver stall shaping; hold_asked is bumped by the stimulus to request a long hold
  int unsigned hold_asked  = 0;
  int unsigned hold_given  = 0;
  int unsigned hold_left   = 0;
  int unsigned stall_span  = 0;
  int unsigned stall_pct   = 0;

  bounded_job_priority_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bjpq_pkg::rsp_t predict_queue_response(bjpq_pkg::req_t r);
    bjpq_pkg::rsp_t res;
    bjpq_pkg::job_t fresh;
    int             slot;
    int             k;
    res = '0;
    if (r.cmd == bjpq_pkg::CMD_PUSH) begin
      // limit test wins over full
      if (shadow_created >= shadow_limit) begin
        res.status = bjpq_pkg::ST_OVER_LIM;
      end else if (shadow_fill >= DEPTH) begin
        res.status = bjpq_pkg::ST_PUSH_FULL;
      end else begin
        fresh = {r.priority_req, r.producer_number, r.producer_pid, r.compute_time,
                 r.job_tag};
        // go ahead of every entry of equal or lower priority
        slot = 0;
        while (slot < int'(shadow_fill) && r.priority_req < shadow_jobs[slot].prio) slot++;
        for (k = int'(shadow_fill); k > slot; k--) shadow_jobs[k] = shadow_jobs[k-1];
        shadow_jobs[slot] = fresh;
        shadow_fill++;
        shadow_created++;
        res.status = bjpq_pkg::ST_PUSHED;
      end
    end else if (shadow_fill == 0) begin
      res.status = bjpq_pkg::ST_POP_EMPTY;
    end else begin
      res.status              = bjpq_pkg::ST_POPPED;
      res.out_priority        = shadow_jobs[0].prio;
      res.out_producer_number = shadow_jobs[0].producer_number;
      res.out_producer_pid    = shadow_jobs[0].producer_pid;
      res.out_compute_time    = shadow_jobs[0].compute_time;
      res.out_job_tag         = shadow_jobs[0].job_tag;
      for (k = 0; k + 1 < int'(shadow_fill); k++) shadow_jobs[k] = shadow_jobs[k+1];
      shadow_fill--;
      shadow_done++;
    end
    res.occupancy       = bjpq_pkg::OCC_W'(shadow_fill);
    res.created_total   = 16'(shadow_created);
    res.completed_total = 16'(shadow_done);
    status_tally[res.status]++;
    return res;
  endfunction

  function automatic string field_diffs(bjpq_pkg::rsp_t got, bjpq_pkg::rsp_t want);
    string s;
    s = "";
    if (got.status !== want.status)
      s = {s, $sformatf(" status exp %0d got %0d", want.status, got.status)};
    if (got.out_priority !== want.out_priority)
      s = {s, $sformatf(" priority exp %0d got %0d", want.out_priority, got.out_priority)};
    if (got.out_producer_number !== want.out_producer_number)
      s = {s, $sformatf(" producer exp %0d got %0d", want.out_producer_number,
                        got.out_producer_number)};
    if (got.out_producer_pid !== want.out_producer_pid)
      s = {s, $sformatf(" pid exp %0h got %0h", want.out_producer_pid, got.out_producer_pid)};
    if (got.out_compute_time !== want.out_compute_time)
      s = {s, $sformatf(" compute exp %0d got %0d", want.out_compute_time,
                        got.out_compute_time)};
    if (got.out_job_tag !== want.out_job_tag)
      s = {s, $sformatf(" tag exp %0h got %0h", want.out_job_tag, got.out_job_tag)};
    if (got.occupancy !== want.occupancy)
      s = {s, $sformatf(" occupancy exp %0d got %0d", want.occupancy, got.occupancy)};
    if (got.created_total !== want.created_total)
      s = {s, $sformatf(" created exp %0d got %0d", want.created_total, got.created_total)};
    if (got.completed_total !== want.completed_total)
      s = {s, $sformatf(" completed exp %0d got %0d", want.completed_total,
                        got.completed_total)};
    return s;
  endfunction

  // Request driver: offer backlog entries in bursts, hold the payload while stalled
  always @(posedge clk) begin : drive_requests
    logic           nxt_valid;
    bjpq_pkg::req_t nxt_data;
    nxt_valid = in_valid;
    nxt_data  = in_data;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        rsp_due.push_back(predict_queue_response(in_data));
        reqs_taken++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (req_backlog.size() > 0) begin
          nxt_data  = req_backlog.pop_front();
          nxt_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            send_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  // Response checker and receiver stall pattern
  always @(posedge clk) begin : watch_responses
    bjpq_pkg::rsp_t want;
    string          diffs;
    logic           nxt_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        rsps_seen++;
        if (rsp_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("response %0d arrived with nothing outstanding: status %0d",
                     rsps_seen, out_data.status);
        end else begin
          want  = rsp_due.pop_front();
          diffs = field_diffs(out_data, want);
          if (diffs != "") begin
            mismatches++;
            if (mismatches <= 10) $display("response %0d mismatch:%s", rsps_seen, diffs);
          end
        end
      end
      if (hold_asked != hold_given) begin
        hold_given = hold_asked;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_stall = 1'b1;
      end else begin
        if (stall_span == 0) begin
          stall_span = $urandom_range(10, 60);
          case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2:    stall_pct = 20;
            3:    stall_pct = 50;
            default: stall_pct = 80;
          endcase
        end
        stall_span--;
        nxt_stall = ($urandom_range(0, 99) < stall_pct);
      end
      out_stall <= nxt_stall;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("no handshake for %0d cycles, %0d responses outstanding", QUIET_LIMIT,
             rsp_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic set_job_limit(logic [15:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    shadow_limit = v;
    limits_set++;
  endtask

  // Hold until every request is taken and every response is back, then let the queue settle;
  // sample mid-cycle so the driver's updates at the edge are already visible
  task automatic wait_drained();
    do @(negedge clk);
    while (req_backlog.size() != 0 || in_valid || rsp_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_push(logic [3:0] prio, logic [7:0] num, logic [21:0] pid,
                          logic [3:0] ct, logic [16:0] tag);
    bjpq_pkg::req_t r;
    r = {bjpq_pkg::CMD_PUSH, prio, num, pid, ct, tag};
    req_backlog.push_back(r);
  endtask

  task automatic add_pop();
    bjpq_pkg::req_t r;
    // payload of a pop is ignored; randomize it anyway
    r = {bjpq_pkg::CMD_POP, 4'($urandom), 8'($urandom), 22'($urandom), 4'($urandom),
         17'($urandom)};
    req_backlog.push_back(r);
  endtask

  // Runs of push-heavy or pop-heavy traffic so the queue swings between empty and full
  task automatic add_random_mix(int unsigned n);
    int unsigned    left;
    int unsigned    run;
    int unsigned    push_pct;
    bjpq_pkg::req_t r;
    left = n;
    while (left > 0) begin
      run      = $urandom_range(1, 14);
      push_pct = ($urandom_range(0, 1) == 1) ? 85 : 20;
      while (run > 0 && left > 0) begin
        r.priority_req    = 4'($urandom);
        r.producer_number = 8'($urandom);
        r.producer_pid    = 22'($urandom);
        r.compute_time    = 4'($urandom);
        r.job_tag         = 17'($urandom);
        // crowd priorities now and then to force ties
        if ($urandom_range(0, 2) == 0) r.priority_req = 4'($urandom_range(6, 8));
        r.cmd = ($urandom_range(0, 99) < push_pct) ? bjpq_pkg::CMD_PUSH : bjpq_pkg::CMD_POP;
        req_backlog.push_back(r);
        run--;
        left--;
      end
    end
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // limit is zero out of reset: empty pop, then a rejected push
    add_pop();
    add_push(4'hF, 8'hFF, 22'h3FFFFF, 4'hF, 17'h1FFFF);
    wait_drained();

    // fill with ties at both ends and in the middle, then one push too many
    set_job_limit(16'd10);
    add_push(4'hF, 8'hFF, 22'h3FFFFF, 4'hF, 17'h1FFFF);
    add_push(4'h0, 8'h00, 22'h000000, 4'h0, 17'h00000);
    add_push(4'h7, 8'hA5, 22'h155555, 4'h5, 17'h0AAAA);
    add_push(4'h7, 8'h5A, 22'h2AAAAA, 4'hA, 17'h15555);
    add_push(4'h0, 8'h01, 22'h000001, 4'h1, 17'h00001);
    add_push(4'hF, 8'h80, 22'h200000, 4'h8, 17'h10000);
    add_push(4'h8, 8'h7F, 22'h1FFFFF, 4'h7, 17'h0FFFF);
    add_push(4'h3, 8'h3C, 22'h0F0F0F, 4'h3, 17'h0C3C3);
    add_push(4'hC, 8'hC3, 22'h30F0F0, 4'hC, 17'h13C3C);
    wait_drained();

    // full and at the limit together, then drain past empty
    set_job_limit(16'd8);
    add_push(4'hF, 8'hFF, 22'h3FFFFF, 4'hF, 17'h1FFFF);
    repeat (DEPTH + 1) add_pop();
    wait_drained();

    set_job_limit(16'hFFFF);
    hold_asked++;
    add_random_mix(200);
    wait_drained();

    // limit runs out partway through
    set_job_limit(16'(shadow_created + 20));
    add_random_mix(100);
    wait_drained();

    set_job_limit(16'd1);
    add_random_mix(40);
    wait_drained();

    set_job_limit(16'hFFFF);
    hold_asked++;
    add_random_mix(150);
    wait_drained();

    $display("%0d requests, %0d responses, %0d job-limit writes, %0d mismatches",
             reqs_taken, rsps_seen, limits_set, mismatches);
    $display("pushed %0d, full %0d, over limit %0d, popped %0d, empty pops %0d",
             status_tally[bjpq_pkg::ST_PUSHED], status_tally[bjpq_pkg::ST_PUSH_FULL],
             status_tally[bjpq_pkg::ST_OVER_LIM], status_tally[bjpq_pkg::ST_POPPED],
             status_tally[bjpq_pkg::ST_POP_EMPTY]);
    if (mismatches == 0 && rsp_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
